@@ src/next_fit_block_allocator_top_macros.svh @@
// Assertion macros for the next-fit block allocator.
`ifndef NEXT_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define NEXT_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during rst.
`define NFBA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, off during rst.
`define NFBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NFBA_ASSERT_SAME(label, ante, cons, msg)
`define NFBA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ src/nfba_pkg.sv @@
// Shared constants, types and codes of the next-fit block allocator.
package nfba_pkg;

  localparam int HEAP_WORDS   = 1024;
  localparam int ADDR_W       = $clog2(HEAP_WORDS);
  localparam int IDX_W        = ADDR_W + 1;
  localparam int SIZE_W       = ADDR_W;
  localparam int HDR_W        = SIZE_W + 1;
  localparam int BYTES_W      = 13;
  localparam int WORD_SHIFT   = 2;
  localparam int WORDS_W      = BYTES_W + 1 - WORD_SHIFT;
  localparam int SKIP_W       = IDX_W + 1;
  localparam int SUM_W        = BYTES_W + 1;
  localparam int WALK_LIMIT   = HEAP_WORDS - 2;
  localparam int STATUS_W     = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              used;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture a new request
    logic clr_wr;    // write one zero header of the clearing pass
    logic rd;        // read the header at the walk offset
    logic fail;      // finish with the early failure code
    logic chk;       // evaluate the header just read, commit if found
    logic out_load;  // move the pending result to the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic is_free;
    logic early_fail;
    logic found;
  } sts_t;

endpackage

@@ src/nfba_ifs.sv @@
// Request and response channel interfaces of the next-fit block allocator.
interface nfba_req_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [nfba_pkg::BYTES_W-1:0] size_bytes;
  logic [nfba_pkg::ADDR_W-1:0]  payload_address;
  modport source(output valid, output mode, output size_bytes, output payload_address,
                 input ready);
  modport sink(input valid, input mode, input size_bytes, input payload_address,
               output ready);
endinterface

interface nfba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [nfba_pkg::STATUS_W-1:0] status;
  logic [nfba_pkg::ADDR_W-1:0]   result_address;
  modport source(output valid, output status, output result_address, input ready);
  modport sink(input valid, input status, input result_address, output ready);
endinterface

@@ src/nfba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module nfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/nfba_datapath.sv @@
// Datapath: header RAM, walk registers, cursor and result registers.
module nfba_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  nfba_pkg::cmd_t                cmd,
  output nfba_pkg::sts_t                sts,
  input  logic                          mode,
  input  logic [nfba_pkg::BYTES_W-1:0]  size_bytes,
  input  logic [nfba_pkg::ADDR_W-1:0]   payload_address,
  output logic [nfba_pkg::STATUS_W-1:0] status,
  output logic [nfba_pkg::ADDR_W-1:0]   result_address
);

  logic [nfba_pkg::ADDR_W-1:0]  cursor;
  logic [nfba_pkg::ADDR_W-1:0]  clr_cnt;
  logic [nfba_pkg::IDX_W-1:0]   idx;
  logic [nfba_pkg::SKIP_W-1:0]  skipped;
  logic [nfba_pkg::WORDS_W-1:0] words;
  logic                         is_free;
  logic                         addr_zero;
  nfba_pkg::status_t            pend_status;
  logic [nfba_pkg::ADDR_W-1:0]  pend_addr;
  nfba_pkg::status_t            out_status;
  logic [nfba_pkg::ADDR_W-1:0]  out_addr;

  logic [nfba_pkg::HDR_W-1:0]   rdata;
  nfba_pkg::hdr_t               rd_hdr;
  nfba_pkg::hdr_t               wr_hdr;
  logic                         ram_we;
  logic [nfba_pkg::ADDR_W-1:0]  ram_waddr;
  logic [nfba_pkg::HDR_W-1:0]   ram_wdata;
  logic                         hdr_found;
  logic                         no_room;
  logic                         free_bad;
  logic                         walk_limit;
  logic                         wr_en;

  nfba_ram #(
    .WIDTH(nfba_pkg::HDR_W),
    .DEPTH(nfba_pkg::HEAP_WORDS)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd),
    .raddr(idx[nfba_pkg::ADDR_W-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    rd_hdr    = nfba_pkg::hdr_t'(rdata);
    hdr_found = (rd_hdr.size == '0) ||
                (!rd_hdr.used &&
                 nfba_pkg::WORDS_W'(rd_hdr.size) >= words);
    no_room   = nfba_pkg::SUM_W'(words) + nfba_pkg::SUM_W'(idx) + nfba_pkg::SUM_W'(1)
                > nfba_pkg::SUM_W'(nfba_pkg::HEAP_WORDS);
    free_bad  = (rd_hdr.size == '0) || !rd_hdr.used;
    walk_limit = (idx >= nfba_pkg::IDX_W'(nfba_pkg::HEAP_WORDS)) ||
                 (nfba_pkg::SUM_W'(skipped) + nfba_pkg::SUM_W'(words)
                  > nfba_pkg::SUM_W'(nfba_pkg::WALK_LIMIT));
    wr_en     = cmd.chk && (is_free ? !free_bad : (hdr_found && !no_room));

    if (is_free) begin
      wr_hdr.used = 1'b0;
      wr_hdr.size = rd_hdr.size;
    end else begin
      wr_hdr.used = 1'b1;
      // a reused free block keeps its size; the end marker takes the request
      wr_hdr.size = (rd_hdr.used || rd_hdr.size == '0) ?
                    words[nfba_pkg::SIZE_W-1:0] : rd_hdr.size;
    end

    ram_we    = cmd.clr_wr || wr_en;
    ram_waddr = cmd.clr_wr ? clr_cnt : idx[nfba_pkg::ADDR_W-1:0];
    ram_wdata = cmd.clr_wr ? '0 : nfba_pkg::HDR_W'(wr_hdr);

    sts.clear_last = (clr_cnt == nfba_pkg::ADDR_W'(nfba_pkg::HEAP_WORDS - 1));
    sts.is_free    = is_free;
    sts.early_fail = is_free ? addr_zero : walk_limit;
    sts.found      = hdr_found;
  end

  // control state: cursor and clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor  <= '0;
      clr_cnt <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt <= clr_cnt + nfba_pkg::ADDR_W'(1);
      end
      if (cmd.chk && !is_free && hdr_found && rd_hdr.size != '0) begin
        cursor <= idx[nfba_pkg::ADDR_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_free   <= mode;
      addr_zero <= (payload_address == '0);
      words     <= nfba_pkg::WORDS_W'((nfba_pkg::SUM_W'(size_bytes) + nfba_pkg::SUM_W'(3))
                                      >> nfba_pkg::WORD_SHIFT);
      idx       <= mode ? nfba_pkg::IDX_W'(payload_address - nfba_pkg::ADDR_W'(1))
                        : nfba_pkg::IDX_W'(cursor);
      skipped   <= '0;
    end
    if (cmd.fail) begin
      pend_status <= is_free ? nfba_pkg::ST_BADFREE : nfba_pkg::ST_NOMEM;
      pend_addr   <= '0;
    end
    if (cmd.chk) begin
      if (is_free) begin
        pend_status <= free_bad ? nfba_pkg::ST_BADFREE : nfba_pkg::ST_OK;
        pend_addr   <= '0;
      end else if (hdr_found) begin
        pend_status <= no_room ? nfba_pkg::ST_NOMEM : nfba_pkg::ST_OK;
        pend_addr   <= no_room ? '0 : nfba_pkg::ADDR_W'(idx + nfba_pkg::IDX_W'(1));
      end else begin
        skipped <= skipped + nfba_pkg::SKIP_W'(rd_hdr.size);
        idx     <= idx + nfba_pkg::IDX_W'(rd_hdr.size) + nfba_pkg::IDX_W'(1);
      end
    end
    if (cmd.out_load) begin
      out_status <= pend_status;
      out_addr   <= pend_addr;
    end
  end

  assign status         = out_status;
  assign result_address = out_addr;

endmodule

@@ src/nfba_ctrl.sv @@
// Controller: sequences the clearing pass, the header walk and the result transfer.
module nfba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  nfba_pkg::sts_t sts,
  output nfba_pkg::cmd_t cmd
);

  nfba_pkg::state_t state;
  nfba_pkg::state_t state_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nfba_pkg::S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      nfba_pkg::S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = nfba_pkg::S_IDLE;
        end
      end
      nfba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = nfba_pkg::S_READ;
        end
      end
      nfba_pkg::S_READ: begin
        cmd.rd = 1'b1;
        if (sts.early_fail) begin
          cmd.fail   = 1'b1;
          state_next = nfba_pkg::S_DONE;
        end else begin
          state_next = nfba_pkg::S_CHECK;
        end
      end
      nfba_pkg::S_CHECK: begin
        cmd.chk = 1'b1;
        state_next = (sts.is_free || sts.found) ? nfba_pkg::S_DONE : nfba_pkg::S_READ;
      end
      nfba_pkg::S_DONE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = nfba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = nfba_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ src/next_fit_block_allocator_top.sv @@
// Steps: an allocate is loaded in S_IDLE, reads and checks each header visited from the
// cursor (S_READ, S_CHECK) and ends in S_DONE; a free reads and checks one header; a request
// that fails in S_READ (walk limit, payload address 0) goes straight to S_DONE.
// One request at a time; the registered header RAM read port sets the walk pace.
// A finished result sits in the output register while the next request is taken.
// Reset (rst, synchronous): cursor to word 0, then a clearing pass zeroes every header.
`include "next_fit_block_allocator_top_macros.svh"

module next_fit_block_allocator_top (
  input logic       clk,
  input logic       rst,
  nfba_req_if.sink  req,
  nfba_rsp_if.source rsp
);

  nfba_pkg::cmd_t cmd;
  nfba_pkg::sts_t sts;

  // Sequencer: clearing pass after reset, then accept one request, walk the
  // header chain (read, then check) and transfer the result when the slot is free.
  nfba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Header store, walk offset and skipped-size accumulator, cursor, result registers.
  nfba_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .mode           (req.mode),
    .size_bytes     (req.size_bytes),
    .payload_address(req.payload_address),
    .status         (rsp.status),
    .result_address (rsp.result_address)
  );

  // Failed or free results never carry an address; only granted blocks do.
  `NFBA_ASSERT_SAME(a_fail_addr_zero, rsp.valid && rsp.status != nfba_pkg::ST_OK, rsp.result_address == '0, "failure result with nonzero address")
  // No request transfer while the clearing pass writes the header store.
  `NFBA_ASSERT_SAME(a_no_accept_in_clear, cmd.clr_wr, !(req.valid && req.ready), "request accepted during clearing pass")
  // One request at a time: ready drops right after a transfer.
  `NFBA_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready, "second request taken while busy")
  // A header commit and a clearing write never share the write port.
  `NFBA_ASSERT_SAME(a_wr_port_excl, cmd.clr_wr, !cmd.chk && !cmd.rd, "clearing write overlaps walk")

endmodule

@@ dv/nfba_tb_pkg.sv @@
// Request mode codes shared by the allocator testbench files.
package nfba_tb_pkg;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_mode_t;

endpackage

@@ dv/nfba_checker.sv @@
// Checker for the allocator: tracks the heap headers, predicts each reply and compares.
module nfba_checker
  import nfba_pkg::*;
  import nfba_tb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  nfba_req_if  req,
  nfba_rsp_if  rsp,
  input  logic end_of_test,
  output int   fail_count
);

  typedef struct {
    status_t             status;
    logic [ADDR_W-1:0]   addr;
  } reply_t;

  hdr_t              headers [HEAP_WORDS];
  logic [ADDR_W-1:0] cursor;
  reply_t            expected_replies [$];
  int                printed;

  // Cap the printout; every mismatch still counts.
  task automatic report_mismatch(input string what);
    fail_count++;
    if (printed < 200) begin
      $display("MISMATCH @%0t: %s", $realtime, what);
      printed++;
    end
  endtask

  // Next-fit walk from the cursor; grow at the end marker, reuse without split.
  function automatic reply_t grant_block(input logic [BYTES_W-1:0] nbytes);
    reply_t r;
    int     words;
    int     idx;
    int     skipped;
    bit     found;
    r.status = ST_NOMEM;
    r.addr   = '0;
    words    = (int'(nbytes) + 3) >> WORD_SHIFT;
    idx      = int'(cursor);
    skipped  = 0;
    found    = 1'b0;
    for (int steps = 0; steps <= HEAP_WORDS; steps++) begin
      if (idx >= HEAP_WORDS) return r;
      if (skipped + words > WALK_LIMIT) return r;
      if (headers[idx].size == 0 || (!headers[idx].used && int'(headers[idx].size) >= words)) begin
        found = 1'b1;
        break;
      end
      skipped += int'(headers[idx].size);
      idx     += int'(headers[idx].size) + 1;
    end
    if (!found) return r;
    // The cursor moves on reuse even if the room check below fails.
    if (headers[idx].size != 0) cursor = ADDR_W'(idx);
    if (words > HEAP_WORDS - (idx + 1)) return r;
    if (headers[idx].used || headers[idx].size == 0) headers[idx].size = SIZE_W'(words);
    headers[idx].used = 1'b1;
    r.status = ST_OK;
    r.addr   = ADDR_W'(idx + 1);
    return r;
  endfunction

  function automatic reply_t release_block(input logic [ADDR_W-1:0] payload);
    reply_t r;
    int     idx;
    r.status = ST_BADFREE;
    r.addr   = '0;
    if (payload == 0) return r;
    idx = int'(payload) - 1;
    if (headers[idx].size == 0 || !headers[idx].used) return r;
    headers[idx].used = 1'b0;
    r.status = ST_OK;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reply_t want;
    if (rst) begin
      foreach (headers[i]) headers[i] = '0;
      cursor     = '0;
      fail_count = 0;
      printed    = 0;
      expected_replies.delete();
    end else begin
      // Replies first: a reply never belongs to a request taken at the same edge.
      if (rsp.valid && rsp.ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with no request outstanding");
        end else begin
          want = expected_replies.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
          if (rsp.result_address !== want.addr)
            report_mismatch($sformatf("address %0d, expected %0d",
                                      rsp.result_address, want.addr));
        end
      end
      if (req.valid && req.ready) begin
        if (req.mode == REQ_FREE) expected_replies.push_back(release_block(req.payload_address));
        else expected_replies.push_back(grant_block(req.size_bytes));
      end
      if (end_of_test && expected_replies.size() != 0) begin
        report_mismatch($sformatf("%0d replies never arrived", expected_replies.size()));
        expected_replies.delete();
      end
    end
  end

endmodule

@@ dv/tb.sv @@
// Top of the allocator testbench: clock, reset, request and reply traffic, verdict.
module tb;
  import nfba_pkg::*;
  import nfba_tb_pkg::*;

  localparam int RANDOM_ITEMS  = 1400;
  localparam int HOLD_OFF_AT   = 900;   // reply count that starts the long receiver stall
  localparam int HOLD_OFF_LEN  = 200;   // cycles of that stall
  localparam int SYNC_AT       = 1000;  // random item before which the sender drains

  logic clk;
  logic rst;
  logic end_of_test;
  int   fail_count;

  // Traffic bookkeeping, shared between the sender, the receiver and the monitor.
  int   request_count;
  int   reply_count;
  bit   no_idle;
  bit   held_off;
  logic [ADDR_W-1:0] granted_addrs  [$];
  logic [ADDR_W-1:0] released_addrs [$];

  nfba_req_if req_ch();
  nfba_rsp_if rsp_ch();

  next_fit_block_allocator_top DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  nfba_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .end_of_test (end_of_test),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: sized from the slowest legal run (every walk crossing a heap of
  // one-word blocks, every stall taken) with a wide margin on top.
  initial begin
    #60_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Count reply transfers and remember every granted payload address so that
  // free requests can target live blocks.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      reply_count++;
      if (rsp_ch.status == ST_OK && rsp_ch.result_address != 0)
        granted_addrs.push_back(rsp_ch.result_address);
    end
  end

  // Receiver: drop ready about 30% of the time, never during the no-idle
  // stretch, and hold off once for a long stretch so the block backs up.
  initial begin
    rsp_ch.ready = 1'b0;
    held_off     = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst && !held_off && reply_count >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(negedge clk);
      end else begin
        rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  // Offer one request from a falling edge, hold it until the transfer, and
  // return on the next falling edge. Valid stays high between back-to-back items.
  task automatic put_request(input req_mode_t mode, input logic [BYTES_W-1:0] nbytes,
                             input logic [ADDR_W-1:0] payload);
    if (!no_idle && $urandom_range(0, 99) < 30) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.mode            <= mode;
    req_ch.size_bytes      <= nbytes;
    req_ch.payload_address <= payload;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    request_count++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every reply is back.
  task automatic drain_replies();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (reply_count != request_count);
  endtask

  initial begin : stimulus
    int                 roll;
    int                 pick;
    logic [ADDR_W-1:0]  target;
    logic [BYTES_W-1:0] nbytes;

    rst                    = 1'b1;
    end_of_test            = 1'b0;
    no_idle                = 1'b0;
    request_count          = 0;
    reply_count            = 0;
    req_ch.valid           = 1'b0;
    req_ch.mode            = REQ_ALLOC;
    req_ch.size_bytes      = '0;
    req_ch.payload_address = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed part. The block clears its headers after reset; the first
    // request simply waits for ready.
    put_request(REQ_ALLOC, 13'd0, 10'd0);      // zero bytes on the end marker
    put_request(REQ_FREE, 13'd0, 10'd1);       // free of a size-zero header
    put_request(REQ_ALLOC, 13'd1, 10'h3FF);    // grow: the end marker gets a size
    put_request(REQ_ALLOC, 13'd4, 10'd0);
    put_request(REQ_ALLOC, 13'd5, 10'd0);      // rounds up to two words
    put_request(REQ_ALLOC, 13'd4096, 10'd0);   // larger than the walk limit allows
    put_request(REQ_ALLOC, 13'h1FFF, 10'd0);   // largest encodable request
    put_request(REQ_FREE, 13'h1FFF, 10'd3);
    put_request(REQ_FREE, 13'd0, 10'd3);       // double free
    put_request(REQ_FREE, 13'd0, 10'd0);       // payload address zero
    put_request(REQ_FREE, 13'd0, 10'h3FF);     // header past the end marker
    put_request(REQ_FREE, 13'd0, 10'd2);       // inside a payload, not a header
    put_request(REQ_ALLOC, 13'd3, 10'd0);      // reuse the freed block, cursor moves
    put_request(REQ_ALLOC, 13'd0, 10'd0);
    put_request(REQ_ALLOC, 13'd4088, 10'd0);   // exactly at the walk limit from cursor
    put_request(REQ_FREE, 13'd0, 10'd5);
    put_request(REQ_ALLOC, 13'd8, 10'd0);      // reuse a two-word block
    put_request(REQ_FREE, 13'd0, 10'd5);
    put_request(REQ_ALLOC, 13'd0, 10'd0);      // zero bytes take any free block
    put_request(REQ_ALLOC, 13'd4087, 10'd0);
    drain_replies();

    // Random part: mostly allocations of small blocks interleaved with frees of
    // live blocks, plus double frees, stray addresses and a few huge requests.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = (i >= 500 && i < 700);
      if (i == SYNC_AT) drain_replies();
      roll = $urandom_range(0, 99);
      if (roll < 40 && granted_addrs.size() != 0) begin
        pick   = $urandom_range(0, granted_addrs.size() - 1);
        target = granted_addrs[pick];
        granted_addrs.delete(pick);
        released_addrs.push_back(target);
        if (released_addrs.size() > 16) void'(released_addrs.pop_front());
        put_request(REQ_FREE, BYTES_W'($urandom), target);
      end else if (roll < 46 && released_addrs.size() != 0) begin
        pick = $urandom_range(0, released_addrs.size() - 1);
        put_request(REQ_FREE, BYTES_W'($urandom), released_addrs[pick]);
      end else if (roll < 52) begin
        put_request(REQ_FREE, BYTES_W'($urandom), ADDR_W'($urandom));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70)      nbytes = BYTES_W'($urandom_range(0, 64));
        else if (roll < 90) nbytes = BYTES_W'($urandom_range(65, 1024));
        else if (roll < 97) nbytes = BYTES_W'($urandom_range(1025, 4096));
        else                nbytes = BYTES_W'($urandom_range(4097, 8191));
        put_request(REQ_ALLOC, nbytes, ADDR_W'($urandom));
      end
    end
    no_idle = 1'b0;

    // Wind down: every request yields one reply, so a short settle suffices.
    drain_replies();
    repeat (20) @(negedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/nfba_pkg.sv
src/nfba_ifs.sv
src/nfba_ram.sv
src/nfba_datapath.sv
src/nfba_ctrl.sv
src/next_fit_block_allocator_top.sv
dv/nfba_tb_pkg.sv
dv/nfba_checker.sv
dv/tb.sv
